// ----- hdl/block_matrix_multiply_accumulate_macros.svh -----
// ============================================================================
// Assertion macros for the block matrix multiply-accumulate
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ============================================================================
`ifndef BLOCK_MATRIX_MULTIPLY_ACCUMULATE_MACROS_SVH
`define BLOCK_MATRIX_MULTIPLY_ACCUMULATE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define BMMA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("block_matrix_multiply_accumulate: assertion failed");
// Next-cycle implication.
`define BMMA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("block_matrix_multiply_accumulate: assertion failed");
`else
`define BMMA_ASSERT_NOW(lbl, ante, cons)
`define BMMA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- hdl/bmma_pkg.sv -----
// ============================================================================
// Block matrix multiply-accumulate package
// Sizes, field widths, operation codes, sequencer states and address helper.
// ============================================================================
`timescale 1ns / 1ps

package bmma_pkg;

    // Largest block side held in the stores.
    localparam int MAX_BLOCK   = 16;
    localparam int STORE_DEPTH = MAX_BLOCK * MAX_BLOCK;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int IDX_W       = $clog2(MAX_BLOCK);
    localparam int CNT_W       = $clog2(MAX_BLOCK + 1);

    // Beat field widths.
    localparam int MODE_W     = 3;
    localparam int ROW_W      = 4;
    localparam int COL_W      = 4;
    localparam int VALUE_W    = 32;
    localparam int CFG_W      = 5;
    localparam int IN_TDATA_W = 40;
    localparam int PROD_W     = 2 * VALUE_W;
    localparam int FRAC_W     = 16;
    localparam int Q_W        = PROD_W - FRAC_W;
    localparam int SUM_W      = Q_W + 1;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

    // Operation codes carried in tuser.
    typedef enum logic [MODE_W-1:0] {
        MODE_WR_A = 3'd0,
        MODE_WR_B = 3'd1,
        MODE_WR_C = 3'd2,
        MODE_MAC  = 3'd3,
        MODE_RD_C = 3'd4
    } mode_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_MAC_RD,
        ST_MAC_MUL,
        ST_MAC_ACC
    } state_t;

    // Flat store address of element (r, c).
    function automatic logic [ADDR_W-1:0] elem_addr(input int unsigned r,
                                                    input int unsigned c);
        elem_addr = ADDR_W'(r * MAX_BLOCK + c);
    endfunction

endpackage

// ----- hdl/bmma_ram.sv -----
// ============================================================================
// Generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ============================================================================
`timescale 1ns / 1ps

module bmma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hdl/block_matrix_multiply_accumulate.sv -----
// ============================================================================
// Block matrix multiply-accumulate
// C += A * B on square blocks of signed Q16.16 values, one shared MAC unit.
// ============================================================================
// Beats load single elements of A, B or C, read back one element of C, or
// start C += A * B over the block size in use (block_size, clamped to 16).
// A read waits until the output register is free and then loads it (the
// input is not ready while the read waits for that register), and a
// multiply-accumulate runs over all n^3 steps for block side n: one
// multiplier is shared by all steps, and each step has a state reading A, B
// and C, a state multiplying and a state for the saturating add and the
// write back to C. The input is not ready during a multiply-accumulate.
// Products are floored by 16 fraction bits and each addition saturates at
// the signed 32-bit limits. After reset a clearing pass writes zeros to all
// 256 addresses of the three stores, and the input is not ready until it
// ends; loads and reads outside the block size in use are ignored or return
// zero.
`timescale 1ns / 1ps
`include "block_matrix_multiply_accumulate_macros.svh"

module block_matrix_multiply_accumulate (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration: block_size.
    input  logic                              cfg_we,
    input  logic [bmma_pkg::CFG_W-1:0]        cfg_wdata,
    // Input beats.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bmma_pkg::IN_TDATA_W-1:0]   s_tdata,   // row[3:0], col[7:4], value[39:8]
    input  logic [bmma_pkg::MODE_W-1:0]       s_tuser,   // mode[2:0]
    // Result beats.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bmma_pkg::VALUE_W-1:0]      m_tdata    // value_res[31:0]
);

    import bmma_pkg::*;

    state_t state_reg, state_next;

    logic [CFG_W-1:0] block_size_reg;
    logic [CNT_W-1:0] n;
    logic [IDX_W-1:0] n_m1;

    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic             i_last, j_last, k_last, mac_done;

    logic                     s_acc;
    mode_t                    mode;
    logic [ROW_W-1:0]         row;
    logic [COL_W-1:0]         col;
    logic [VALUE_W-1:0]       value;
    logic                     in_range;
    logic [ADDR_W-1:0]        in_addr;

    // Clearing pass position.
    logic [ADDR_W-1:0]        clr_addr_reg, clr_addr_next;
    logic                     rd_inside_reg, rd_inside_next;

    // RAM controls.
    logic                     a_we, b_we, c_we;
    logic                     a_re, b_re, c_re;
    logic [ADDR_W-1:0]        wr_addr;
    logic [VALUE_W-1:0]       ab_wdata;
    logic [VALUE_W-1:0]       c_wdata;
    logic [ADDR_W-1:0]        a_raddr, b_raddr, c_raddr;
    logic [VALUE_W-1:0]       a_rdata, b_rdata, c_rdata;
    logic signed [VALUE_W-1:0] a_val, b_val, c_val;

    // Arithmetic.
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [Q_W-1:0]    q;
    logic signed [SUM_W-1:0]  sum;
    logic [VALUE_W-1:0]       sat;
    logic                     mac_load;

    // Output register.
    logic                     out_load;
    logic                     m_tvalid_reg;
    logic [VALUE_W-1:0]       m_tdata_reg;

    // Beat fields and element address.
    assign s_acc    = s_tvalid && s_tready;
    assign mode     = mode_t'(s_tuser);
    assign row      = s_tdata[ROW_W-1:0];
    assign col      = s_tdata[ROW_W+COL_W-1:ROW_W];
    assign value    = s_tdata[ROW_W+COL_W+VALUE_W-1:ROW_W+COL_W];
    assign in_range = (32'(row) < 32'(n)) && (32'(col) < 32'(n));
    assign in_addr  = elem_addr(32'(row), 32'(col));

    // Block size in use, clamped to the store size.
    always_comb
    begin
        if (32'(block_size_reg) > 32'(MAX_BLOCK))
        begin
            n = CNT_W'(MAX_BLOCK);
        end
        else
        begin
            n = CNT_W'(block_size_reg);
        end
    end
    assign n_m1 = IDX_W'(n - CNT_W'(1));

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_size_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            block_size_reg <= cfg_wdata;
        end
    end

    // Loop position: j innermost, then i, k outermost.
    assign j_last   = (j_reg == n_m1);
    assign i_last   = (i_reg == n_m1);
    assign k_last   = (k_reg == n_m1);
    assign mac_done = j_last && i_last && k_last;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == ADDR_W'(STORE_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_acc)
                begin
                    if (mode == MODE_RD_C)
                    begin
                        state_next = ST_READ;
                    end
                    else if (mode == MODE_MAC && n != '0)
                    begin
                        state_next = ST_MAC_RD;
                    end
                end
            end
            ST_READ:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MAC_RD:  state_next = ST_MAC_MUL;
            ST_MAC_MUL: state_next = ST_MAC_ACC;
            ST_MAC_ACC:
            begin
                state_next = mac_done ? ST_IDLE : ST_MAC_RD;
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: handshake, RAM ports, counters.
    always_comb
    begin
        s_tready       = 1'b0;
        a_we           = 1'b0;
        b_we           = 1'b0;
        c_we           = 1'b0;
        a_re           = 1'b0;
        b_re           = 1'b0;
        c_re           = 1'b0;
        wr_addr        = in_addr;
        ab_wdata       = value;
        c_wdata        = value;
        a_raddr        = elem_addr(32'(i_reg), 32'(k_reg));
        b_raddr        = elem_addr(32'(k_reg), 32'(j_reg));
        c_raddr        = elem_addr(32'(i_reg), 32'(j_reg));
        rd_inside_next = rd_inside_reg;
        clr_addr_next  = clr_addr_reg;
        mac_load       = 1'b0;
        out_load       = 1'b0;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                a_we          = 1'b1;
                b_we          = 1'b1;
                c_we          = 1'b1;
                wr_addr       = clr_addr_reg;
                ab_wdata      = '0;
                c_wdata       = '0;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                i_next   = '0;
                j_next   = '0;
                k_next   = '0;
                if (s_acc)
                begin
                    case (mode)
                        MODE_WR_A: a_we = in_range;
                        MODE_WR_B: b_we = in_range;
                        MODE_WR_C: c_we = in_range;
                        MODE_RD_C:
                        begin
                            c_re           = in_range;
                            c_raddr        = in_addr;
                            rd_inside_next = in_range;
                        end
                        default:   ;
                    endcase
                end
            end
            ST_READ:
            begin
                out_load = !m_tvalid_reg || m_tready;
            end
            ST_MAC_RD:
            begin
                a_re = 1'b1;
                b_re = 1'b1;
                c_re = 1'b1;
            end
            ST_MAC_MUL:
            begin
                mac_load = 1'b1;
            end
            ST_MAC_ACC:
            begin
                c_we    = 1'b1;
                wr_addr = elem_addr(32'(i_reg), 32'(j_reg));
                c_wdata = sat;
                if (!j_last)
                begin
                    j_next = j_reg + IDX_W'(1);
                end
                else
                begin
                    j_next = '0;
                    if (!i_last)
                    begin
                        i_next = i_reg + IDX_W'(1);
                    end
                    else
                    begin
                        i_next = '0;
                        k_next = k_reg + IDX_W'(1);
                    end
                end
            end
            default:    ;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            rd_inside_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            rd_inside_reg <= rd_inside_next;
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Element stores.
    bmma_ram #(.WIDTH(VALUE_W), .DEPTH(STORE_DEPTH)) u_a_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (wr_addr),
        .wdata (ab_wdata),
        .re    (a_re),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    bmma_ram #(.WIDTH(VALUE_W), .DEPTH(STORE_DEPTH)) u_b_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (wr_addr),
        .wdata (ab_wdata),
        .re    (b_re),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    bmma_ram #(.WIDTH(VALUE_W), .DEPTH(STORE_DEPTH)) u_c_ram (
        .clk   (clk),
        .we    (c_we),
        .waddr (wr_addr),
        .wdata (c_wdata),
        .re    (c_re),
        .raddr (c_raddr),
        .rdata (c_rdata)
    );

    // Signed views of the read data.
    assign a_val = signed'(a_rdata);
    assign b_val = signed'(b_rdata);
    assign c_val = signed'(c_rdata);

    // Shared multiplier, registered product.
    always_ff @(posedge clk)
    begin
        if (mac_load)
        begin
            prod_reg <= PROD_W'(a_val) * PROD_W'(b_val);
        end
    end

    // Floor by the fraction bits, then saturating add onto C.
    assign q   = prod_reg[PROD_W-1:FRAC_W];
    assign sum = SUM_W'(c_val) + SUM_W'(q);

    always_comb
    begin
        if (sum > SUM_W'(signed'({1'b0, {(VALUE_W-1){1'b1}}})))
        begin
            sat = {1'b0, {(VALUE_W-1){1'b1}}};
        end
        else if (sum < -SUM_W'(signed'({1'b0, 1'b1, {(VALUE_W-1){1'b0}}})))
        begin
            sat = {1'b1, {(VALUE_W-1){1'b0}}};
        end
        else
        begin
            sat = sum[VALUE_W-1:0];
        end
    end

    // Result register; an out-of-range read returns zero.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_tdata_reg <= rd_inside_reg ? c_val : '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Checks on the sequencer.
    `BMMA_ASSERT_NOW(a_cnt_in_range, state_reg == ST_MAC_ACC,
        32'(i_reg) < 32'(n) && 32'(j_reg) < 32'(n) && 32'(k_reg) < 32'(n))
    `BMMA_ASSERT_NEXT(a_mac_start, s_acc && mode == MODE_MAC && n != '0,
        state_reg == ST_MAC_RD)
    `BMMA_ASSERT_NEXT(a_read_delivers, state_reg == ST_READ && (!m_tvalid_reg || m_tready),
        m_tvalid && state_reg == ST_IDLE)

endmodule

// ----- tb/sv/block_matrix_multiply_accumulate_tb.sv -----
// ============================================================================
// Block matrix multiply-accumulate testbench
// Loads A, B and C elements, runs C += A * B and reads C back over a range of
// block sizes. A built-in predictor tracks the three stores and the block
// size, and every C element read back is compared with its prediction.
// ============================================================================
`timescale 1ns / 1ps

module block_matrix_multiply_accumulate_tb;

    import bmma_pkg::*;

    // Modes that the block must ignore.
    localparam logic [MODE_W-1:0] MODE_RSVD5 = 3'd5;
    localparam logic [MODE_W-1:0] MODE_RSVD6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_RSVD7 = 3'd7;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned IDLE_MAX    = 17;

    localparam logic signed [PROD_W-1:0] SAT_HI = 64'sd2147483647;
    localparam logic signed [PROD_W-1:0] SAT_LO = -64'sd2147483648;

    typedef struct {
        logic [MODE_W-1:0]         mode;
        logic [ROW_W-1:0]          row;
        logic [COL_W-1:0]          col;
        logic signed [VALUE_W-1:0] value;
    } elem_op_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_W-1:0]      cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_TDATA_W-1:0] s_tdata   = '0;   // row[3:0], col[7:4], value[39:8]
    logic [MODE_W-1:0]     s_tuser   = '0;   // mode[2:0]
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [VALUE_W-1:0]    m_tdata;          // value_res[31:0]

    // Predicted state of the block.
    logic [CFG_W-1:0]          block_size_q = CFG_RESET;
    logic signed [VALUE_W-1:0] a_elems [STORE_DEPTH] = '{default: '0};
    logic signed [VALUE_W-1:0] b_elems [STORE_DEPTH] = '{default: '0};
    logic signed [VALUE_W-1:0] c_elems [STORE_DEPTH] = '{default: '0};

    elem_op_t           pending_ops [$];
    logic [VALUE_W-1:0] c_reads_due [$];
    elem_op_t           cur_op;

    logic        in_taken       = 1'b0;
    logic        out_taken      = 1'b0;
    int unsigned send_wait      = 0;
    int unsigned recv_wait      = 0;
    int unsigned send_gap_max   = IDLE_MAX;
    int unsigned recv_stall_max = IDLE_MAX;
    int unsigned ops_queued     = 0;
    int unsigned err_count      = 0;
    int unsigned cycle_count    = 0;

    block_matrix_multiply_accumulate dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // 2 ns clock.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Side length actually in use; larger settings clamp to the store size.
    function automatic int unsigned eff_size(input logic [CFG_W-1:0] setting);
        return (setting > MAX_BLOCK) ? MAX_BLOCK : setting;
    endfunction

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t ns: %s", $time, what);
        err_count++;
    endtask

    // Predict the effect of one accepted beat on the stores.
    task automatic apply_to_blocks(input elem_op_t op);
        int unsigned n;
        int unsigned idx;
        bit in_block;
        logic signed [PROD_W-1:0] prod;
        logic signed [PROD_W-1:0] acc;
        n = eff_size(block_size_q);
        idx = op.row * MAX_BLOCK + op.col;
        in_block = (op.row < n) && (op.col < n);
        case (op.mode)
            MODE_WR_A: if (in_block) a_elems[idx] = op.value;
            MODE_WR_B: if (in_block) b_elems[idx] = op.value;
            MODE_WR_C: if (in_block) c_elems[idx] = op.value;
            MODE_MAC:
            begin
                // k outermost; every single addition saturates.
                for (int unsigned k = 0; k < n; k++)
                    for (int unsigned i = 0; i < n; i++)
                        for (int unsigned j = 0; j < n; j++)
                        begin
                            prod = a_elems[i * MAX_BLOCK + k] * b_elems[k * MAX_BLOCK + j];
                            acc = c_elems[i * MAX_BLOCK + j] + (prod >>> FRAC_W);
                            if (acc > SAT_HI)
                                c_elems[i * MAX_BLOCK + j] = SAT_HI[VALUE_W-1:0];
                            else if (acc < SAT_LO)
                                c_elems[i * MAX_BLOCK + j] = SAT_LO[VALUE_W-1:0];
                            else
                                c_elems[i * MAX_BLOCK + j] = acc[VALUE_W-1:0];
                        end
            end
            MODE_RD_C: c_reads_due.push_back(in_block ? c_elems[idx] : '0);
            default: ;
        endcase
    endtask

    // Predictor update and result check on the rising edge.
    always @(posedge clk)
    begin : observe
        logic [VALUE_W-1:0] want;
        if (rst_n)
        begin
            if (cfg_we)
                block_size_q = cfg_wdata;
            if (s_tvalid && s_tready)
                apply_to_blocks(cur_op);
            if (m_tvalid && m_tready)
            begin
                if (c_reads_due.size() == 0)
                    report_mismatch($sformatf("unexpected result beat %h", m_tdata));
                else
                begin
                    want = c_reads_due.pop_front();
                    if (m_tdata !== want)
                        report_mismatch($sformatf("value_res got %h, expected %h",
                                                  m_tdata, want));
                end
            end
        end
        in_taken  <= rst_n && s_tvalid && s_tready;
        out_taken <= rst_n && m_tvalid && m_tready;
    end

    // Input driver: one beat per queued item, with a random gap before each.
    always @(negedge clk)
    begin : feed_items
        logic next_valid;
        next_valid = s_tvalid;
        if (rst_n)
        begin
            if (in_taken)
            begin
                next_valid = 1'b0;
                send_wait = $urandom_range(0, send_gap_max);
            end
            if (!next_valid && pending_ops.size() != 0)
            begin
                if (send_wait != 0)
                    send_wait--;
                else
                begin
                    cur_op = pending_ops.pop_front();
                    s_tdata <= {cur_op.value, cur_op.col, cur_op.row};
                    s_tuser <= cur_op.mode;
                    next_valid = 1'b1;
                end
            end
        end
        s_tvalid <= next_valid;
    end

    // Result side: a random stall ahead of every result beat.
    always @(negedge clk)
    begin : take_results
        if (out_taken)
            recv_wait = $urandom_range(0, recv_stall_max);
        if (recv_wait != 0 && m_tvalid)
            recv_wait--;
        m_tready <= rst_n && (recv_wait == 0);
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic queue_op(input logic [MODE_W-1:0] mode, input logic [ROW_W-1:0] row,
                            input logic [COL_W-1:0] col, input logic [VALUE_W-1:0] value);
        elem_op_t op;
        op.mode  = mode;
        op.row   = row;
        op.col   = col;
        op.value = value;
        pending_ops.push_back(op);
        ops_queued++;
    endtask

    // Waits until every beat is sent and every read has returned; with settle
    // set, also lets a trailing multiply-accumulate run out.
    task automatic drain_block(input bit settle);
        int unsigned n;
        while (pending_ops.size() != 0 || s_tvalid || c_reads_due.size() != 0)
            @(posedge clk);
        if (settle)
        begin
            n = eff_size(block_size_q);
            repeat (3 * n * n * n + 16) @(posedge clk);
        end
    endtask

    task automatic write_block_size(input logic [CFG_W-1:0] setting);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= setting;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Mostly small Q16.16 values so sums stay meaningful, plus full range
    // and the signed limits.
    function automatic logic [VALUE_W-1:0] rand_value();
        logic [VALUE_W-1:0] v;
        v = $urandom;
        case ($urandom_range(0, 7))
            0: ;
            1: v = v[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: v = {{12{v[31]}}, v[31:12]};
        endcase
        return v;
    endfunction

    // Index inside the block, now and then anywhere in the store.
    function automatic logic [ROW_W-1:0] pick_index(input int unsigned n);
        if (n == 0 || $urandom_range(0, 7) == 0)
            return ROW_W'($urandom_range(0, MAX_BLOCK - 1));
        return ROW_W'($urandom_range(0, n - 1));
    endfunction

    // One load, compute and read-back sequence with random content.
    task automatic add_job(input int unsigned n);
        logic [MODE_W-1:0] m;
        int unsigned loads;
        int unsigned reads;
        loads = $urandom_range(2, 6);
        reads = $urandom_range(1, 4);
        repeat (loads)
        begin
            case ($urandom_range(0, 2))
                0: m = MODE_WR_A;
                1: m = MODE_WR_B;
                default: m = MODE_WR_C;
            endcase
            queue_op(m, pick_index(n), pick_index(n), rand_value());
        end
        queue_op(MODE_MAC, ROW_W'($urandom_range(0, 15)), COL_W'($urandom_range(0, 15)),
                 $urandom);
        repeat (reads)
            queue_op(MODE_RD_C, pick_index(n), pick_index(n), rand_value());
        // Occasional stray beat of any mode, a read in place of a compute for sizes above 8.
        if ($urandom_range(0, 3) == 0)
        begin
            m = MODE_W'($urandom_range(0, 7));
            if (m == MODE_MAC && n > 8)
                m = MODE_RD_C;
            queue_op(m, ROW_W'($urandom_range(0, 15)), COL_W'($urandom_range(0, 15)),
                     $urandom);
        end
    endtask

    // Settle, pick idle profiles, set the size and queue some jobs.
    task automatic size_phase(input logic [CFG_W-1:0] setting, input int unsigned jobs,
                              input bit pause_each);
        drain_block(1'b1);
        send_gap_max   = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
        recv_stall_max = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
        write_block_size(setting);
        repeat (jobs)
        begin
            add_job(eff_size(setting));
            if (pause_each)
                drain_block(1'b0);
        end
    endtask

    // Stimulus sequence.
    initial
    begin : run
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset size (16): cleared store, saturation both ways, floor rounding.
        queue_op(MODE_RD_C, 4'd15, 4'd15, 32'h0);
        queue_op(MODE_WR_A, 4'd15, 4'd15, 32'h7FFF_FFFF);
        queue_op(MODE_WR_B, 4'd15, 4'd15, 32'h7FFF_FFFF);
        queue_op(MODE_WR_C, 4'd15, 4'd15, 32'h7FFF_0000);
        queue_op(MODE_WR_A, 4'd0, 4'd15, 32'h8000_0000);
        queue_op(MODE_WR_B, 4'd15, 4'd0, 32'h7FFF_FFFF);
        queue_op(MODE_WR_C, 4'd0, 4'd0, 32'h8000_0001);
        queue_op(MODE_WR_A, 4'd1, 4'd1, 32'hFFFF_FFFF);
        queue_op(MODE_WR_B, 4'd1, 4'd1, 32'h0000_0001);
        queue_op(MODE_WR_A, 4'd2, 4'd3, 32'h0001_8000);
        queue_op(MODE_WR_B, 4'd3, 4'd2, 32'hFFFE_8000);
        queue_op(MODE_RSVD5, 4'd3, 4'd3, 32'hFFFF_FFFF);
        queue_op(MODE_RSVD6, 4'd15, 4'd0, 32'h5555_AAAA);
        queue_op(MODE_RSVD7, 4'd0, 4'd15, 32'hAAAA_5555);
        queue_op(MODE_MAC, 4'd9, 4'd6, 32'hDEAD_BEEF);
        queue_op(MODE_RD_C, 4'd15, 4'd15, 32'h0);
        queue_op(MODE_RD_C, 4'd0, 4'd0, 32'h0);
        queue_op(MODE_RD_C, 4'd1, 4'd1, 32'h0);
        queue_op(MODE_RD_C, 4'd2, 4'd2, 32'h0);
        queue_op(MODE_RD_C, 4'd15, 4'd0, 32'h0);

        // Size 2: writes and reads outside the block.
        drain_block(1'b1);
        write_block_size(5'd2);
        queue_op(MODE_WR_C, 4'd0, 4'd2, 32'h1234_5678);
        queue_op(MODE_RD_C, 4'd0, 4'd2, 32'h0);
        queue_op(MODE_RD_C, 4'd1, 4'd1, 32'h0);

        // Size 0: nothing in range, compute does nothing.
        drain_block(1'b1);
        write_block_size(5'd0);
        queue_op(MODE_MAC, 4'd0, 4'd0, 32'h0);
        queue_op(MODE_RD_C, 4'd0, 4'd0, 32'h0);

        // Random sequences across sizes; the size 3 phase waits for every
        // read after each job.
        size_phase(5'd4, 2, 1'b0);
        size_phase(5'd2, 2, 1'b0);
        size_phase(5'd3, 2, 1'b1);
        size_phase(5'd31, 1, 1'b0);
        size_phase(5'd16, 1, 1'b0);
        size_phase(5'd8, 2, 1'b0);
        size_phase(5'd1, 2, 1'b0);
        size_phase(5'd0, 1, 1'b0);
        size_phase(5'd5, 2, 1'b0);
        while (ops_queued < 140)
            add_job(5);

        drain_block(1'b1);
        if (err_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/bmma_pkg.sv
hdl/bmma_ram.sv
hdl/block_matrix_multiply_accumulate.sv
tb/sv/block_matrix_multiply_accumulate_tb.sv
